/* rtl/core/dns_name_label_encoder_unit_assert.svh */
// assertion macros shared by the label encoder rtl
// depends on nothing; included by the files that carry assertions
`ifndef DNS_NAME_LABEL_ENCODER_UNIT_ASSERT_SVH
`define DNS_NAME_LABEL_ENCODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define DNLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dnle assertion failed");
// next-cycle implication, checked out of reset
`define DNLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dnle assertion failed");
`else
`define DNLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DNLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/dnle_pkg.sv */
// shared types and constants of the dns name label encoder
// depends on nothing
package dnle_pkg;

  localparam int LABEL_MAX = 62;
  localparam int CNT_W     = $clog2(LABEL_MAX + 1);
  localparam int RAM_AW    = CNT_W + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] NUL_CHAR = 8'h00;

  typedef struct packed {
    logic             is_end;
    logic             bank;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } flush_cmd_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LEN,
    BK_RD,
    BK_DATA,
    BK_TERM
  } back_state_t;

endpackage

/* rtl/core/dnle_in_if.sv */
// input channel of the label encoder: one name character or end mark per word
// depends on nothing
interface dnle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       end_of_name;

  modport source (output valid, output name_byte, output end_of_name, input ready);
  modport sink (input valid, input name_byte, input end_of_name, output ready);
endinterface

/* rtl/core/dnle_out_if.sv */
// output channel of the label encoder: one wire-format byte per word
// depends on nothing
interface dnle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       overflow;

  modport source (output valid, output out_byte, output last, output overflow, input ready);
  modport sink (input valid, input out_byte, input last, input overflow, output ready);
endinterface

/* rtl/core/dnle_ram.sv */
// generic single-write, single-read ram with registered read data
// depends on nothing
module dnle_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/dnle_cmd_fifo.sv */
// two-entry queue of flush commands between front and back
// depends on dnle_pkg and the assertion macro header
`include "dns_name_label_encoder_unit_assert.svh"
module dnle_cmd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dnle_pkg::flush_cmd_t push_cmd,
  input  logic                pop,
  output dnle_pkg::flush_cmd_t head,
  output logic                empty,
  output logic                full
);
  import dnle_pkg::*;

  flush_cmd_t           q_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  `DNLE_ASSERT_IMPLY(a_cmd_no_overrun, clk, rst_n, push, !full)
  `DNLE_ASSERT_IMPLY(a_cmd_no_underrun, clk, rst_n, pop, !empty)

endmodule

/* rtl/core/dnle_front.sv */
// front end: takes name characters, buffers them in the label ram, queues flushes
// depends on dnle_pkg, dnle_in_if and the assertion macro header
`include "dns_name_label_encoder_unit_assert.svh"
module dnle_front (
  input  logic                 clk,
  input  logic                 rst_n,
  dnle_in_if.sink              in_ch,
  input  logic                 cmd_full,
  output logic                 cmd_push,
  output dnle_pkg::flush_cmd_t cmd_data,
  output dnle_pkg::ram_wr_t    ram_wr
);
  import dnle_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             bank_r, bank_nxt;
  logic             take;
  logic             is_flush;

  // a new label may fill one bank while the back drains the other
  assign in_ch.ready = !cmd_full;
  assign take        = in_ch.valid && in_ch.ready;
  assign is_flush    = in_ch.end_of_name || (in_ch.name_byte == DOT_CHAR);

  assign cmd_push        = take && is_flush;
  assign cmd_data.is_end = in_ch.end_of_name;
  assign cmd_data.bank   = bank_r;
  assign cmd_data.count  = cnt_r;
  assign cmd_data.ovf    = ovf_r;

  assign ram_wr.en   = take && !is_flush && (cnt_r < CNT_W'(LABEL_MAX));
  assign ram_wr.addr = {bank_r, cnt_r};
  assign ram_wr.data = in_ch.name_byte;

  always_comb begin
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    bank_nxt = bank_r;
    if (take) begin
      if (is_flush) begin
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
        bank_nxt = !bank_r;
      end else if (cnt_r < CNT_W'(LABEL_MAX)) begin
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      bank_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      bank_r <= bank_nxt;
    end
  end

  `DNLE_ASSERT_IMPLY(a_front_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(LABEL_MAX))

endmodule

/* rtl/core/dnle_back.sv */
// back end: drains queued flushes from the label ram into the output register
// depends on dnle_pkg, dnle_out_if and the assertion macro header
`include "dns_name_label_encoder_unit_assert.svh"
module dnle_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dnle_pkg::flush_cmd_t cmd,
  input  logic                 cmd_empty,
  output logic                 cmd_pop,
  output logic                 ram_re,
  output logic [dnle_pkg::RAM_AW-1:0] ram_raddr,
  input  logic [7:0]           ram_rdata,
  dnle_out_if.source           out_ch
);
  import dnle_pkg::*;

  back_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] idx_inc;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             out_ovf_r;
  logic             out_free;
  logic             ld;
  logic [7:0]       ld_byte;
  logic             ld_last;
  logic             ld_ovf;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign idx_inc   = idx_r + 1'b1;
  assign ram_raddr = {cmd.bank, idx_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) state_nxt = BK_LEN;
      end
      BK_LEN: begin
        if (out_free) begin
          if (cmd.count == '0) begin
            state_nxt = cmd.is_end ? BK_TERM : BK_IDLE;
          end else begin
            state_nxt = BK_RD;
          end
        end
      end
      BK_RD: begin
        state_nxt = BK_DATA;
      end
      BK_DATA: begin
        if (out_free) begin
          if (idx_inc == cmd.count) begin
            state_nxt = cmd.is_end ? BK_TERM : BK_IDLE;
          end else begin
            state_nxt = BK_RD;
          end
        end
      end
      BK_TERM: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    ld      = 1'b0;
    ld_byte = NUL_CHAR;
    ld_last = 1'b0;
    ld_ovf  = 1'b0;
    cmd_pop = 1'b0;
    ram_re  = 1'b0;
    idx_nxt = idx_r;
    case (state_r)
      BK_IDLE: begin
        idx_nxt = '0;
      end
      BK_LEN: begin
        ld_byte = 8'(cmd.count);
        ld_last = !cmd.is_end && (cmd.count == '0);
        ld_ovf  = cmd.ovf;
        if (out_free) begin
          ld      = 1'b1;
          cmd_pop = !cmd.is_end && (cmd.count == '0);
        end
      end
      BK_RD: begin
        ram_re = 1'b1;
      end
      BK_DATA: begin
        ld_byte = ram_rdata;
        ld_last = !cmd.is_end && (idx_inc == cmd.count);
        ld_ovf  = cmd.ovf;
        if (out_free) begin
          ld      = 1'b1;
          idx_nxt = idx_inc;
          cmd_pop = !cmd.is_end && (idx_inc == cmd.count);
        end
      end
      BK_TERM: begin
        ld_byte = NUL_CHAR;
        ld_last = 1'b1;
        if (out_free) begin
          ld      = 1'b1;
          cmd_pop = 1'b1;
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_byte_r <= ld_byte;
      out_last_r <= ld_last;
      out_ovf_r  <= ld_ovf;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;
  assign out_ch.overflow = out_ovf_r;

  `DNLE_ASSERT_IMPLY(a_back_busy_has_cmd, clk, rst_n, state_r != BK_IDLE, !cmd_empty)
  `DNLE_ASSERT_IMPLY(a_back_term_on_end, clk, rst_n, state_r == BK_TERM, cmd.is_end)

endmodule

/* rtl/core/dns_name_label_encoder_unit.sv */
// top level of the dns name label encoder
// depends on dnle_pkg, dnle_in_if, dnle_out_if, dnle_ram, dnle_cmd_fifo, dnle_front, dnle_back
//
// Encodes a dotted host name, one character per input word, into dns wire
// format: each label comes out as its length byte followed by its characters,
// and an end-of-name word closes the current label (a zero length byte if it
// is empty) and then sends the terminating zero byte. A dot closes a label the
// same way, with last set on its final byte; a label longer than 62 characters
// keeps the first 62, and every byte of its run carries overflow. Flow: an
// ordinary character is taken and gives no output. A closing word is taken
// and queued as a flush; the back end picks it up from idle, sends the length
// byte, then for each character a label ram read followed by the load into
// the output register, plus the terminator on an end of name. The front
// keeps taking characters of the next label while the back end drains the
// previous one, because the label ram holds two banks; input stalls only
// while two closed labels are waiting or being sent.
module dns_name_label_encoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  dnle_in_if.sink    in_ch,
  dnle_out_if.source out_ch
);
  import dnle_pkg::*;

  // flush command queue between the two halves
  flush_cmd_t          cmd_push_data;
  flush_cmd_t          cmd_head;
  logic                cmd_push;
  logic                cmd_pop;
  logic                cmd_empty;
  logic                cmd_full;

  // label ram: bank bit on top, character index below
  ram_wr_t             ram_wr;
  logic                ram_re;
  logic [RAM_AW-1:0]   ram_raddr;
  logic [7:0]          ram_rdata;

  // front: classifies each word, stores characters, queues a flush on dot or end
  dnle_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_push_data),
    .ram_wr   (ram_wr)
  );

  // two entries: one label being sent, one closed and waiting
  dnle_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd_push_data),
    .pop      (cmd_pop),
    .head     (cmd_head),
    .empty    (cmd_empty),
    .full     (cmd_full)
  );

  dnle_ram #(
    .Width (8),
    .Depth (RAM_DEPTH)
  ) u_label_ram (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // back: length byte, characters, optional terminator, through an output register
  dnle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_ch    (out_ch)
  );

endmodule

/* tb/sv/dns_name_label_encoder_unit_test.sv */
// self-checking test of the dns name label encoder: feeds dotted names and
// compares every wire-format byte against a behavioral encoder held in the test
// depends on dnle_pkg, dnle_in_if, dnle_out_if and dns_name_label_encoder_unit
`timescale 1ns / 1ps

module dns_name_label_encoder_unit_test;
  import dnle_pkg::*;

  // one input word: a name character, or the end-of-name mark
  typedef struct {
    logic [7:0] name_byte;
    logic       end_of_name;
  } name_word_t;

  // one encoded output word as the encoder should send it
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } wire_byte_t;

  logic clk;
  logic rst_n;

  dnle_in_if  in_ch ();
  dnle_out_if out_ch ();

  dns_name_label_encoder_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // words waiting to be sent, and encoded bytes still owed by the block
  name_word_t pending_words[$];
  wire_byte_t expected_bytes[$];
  name_word_t next_word;
  wire_byte_t seen_byte;
  wire_byte_t want_byte;

  int words_total;
  int words_accepted;
  int errors;

  // behavioral copy of the label buffer
  logic [7:0] label_chars[LABEL_MAX];
  int         label_len;
  logic       label_lost;

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // behavioral encoder
  // ---------------------------------------------------------------------------

  // emits length byte then the kept characters; last goes on the final byte
  // only when the run ends here (a dot), not when a terminator follows
  task automatic close_label(input bit mark_last);
    wire_byte_t b;
    b.ovf  = label_lost;
    b.data = 8'(label_len);
    b.last = mark_last && (label_len == 0);
    expected_bytes.push_back(b);
    for (int i = 0; i < label_len; i++) begin
      b.data = label_chars[i];
      b.last = mark_last && (i == label_len - 1);
      expected_bytes.push_back(b);
    end
    label_len  = 0;
    label_lost = 1'b0;
  endtask

  task automatic encode_word(input logic [7:0] ch, input logic eon);
    wire_byte_t term;
    if (eon) begin
      // close whatever is open (maybe empty), then the root zero byte
      close_label(1'b0);
      term.data = NUL_CHAR;
      term.last = 1'b1;
      term.ovf  = 1'b0;
      expected_bytes.push_back(term);
    end else if (ch == DOT_CHAR) begin
      close_label(1'b1);
    end else if (label_len < LABEL_MAX) begin
      // nul and any other byte are plain characters here
      label_chars[label_len] = ch;
      label_len++;
    end else begin
      // label full: character dropped, run gets flagged
      label_lost = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // idle schedule: sender 23 / receiver 53, then swapped, then no idling
  // ---------------------------------------------------------------------------

  function automatic int idle_phase();
    if (words_accepted < words_total / 3) return 0;
    if (words_accepted < (2 * words_total) / 3) return 1;
    return 2;
  endfunction

  function automatic int tx_idle_pct();
    case (idle_phase())
      0: return 23;
      1: return 53;
      default: return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct();
    case (idle_phase())
      0: return 53;
      1: return 23;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: predicts on every accepted word, then offers the next one
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        encode_word(in_ch.name_byte, in_ch.end_of_name);
        words_accepted++;
      end
      // valid only changes once the current word is gone or none is up
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct()) begin
          next_word = pending_words.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.name_byte   <= next_word.name_byte;
          in_ch.end_of_name <= next_word.end_of_name;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each accepted byte against the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen_byte.data = out_ch.out_byte;
        seen_byte.last = out_ch.last;
        seen_byte.ovf  = out_ch.overflow;
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected word: got byte %02h last %0b ovf %0b",
                   $time, seen_byte.data, seen_byte.last, seen_byte.ovf);
          errors++;
        end else begin
          want_byte = expected_bytes.pop_front();
          if (seen_byte.data !== want_byte.data || seen_byte.last !== want_byte.last ||
              seen_byte.ovf !== want_byte.ovf) begin
            $display("%0t: mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b (byte/last/ovf)",
                     $time, want_byte.data, want_byte.last, want_byte.ovf,
                     seen_byte.data, seen_byte.last, seen_byte.ovf);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_word(input logic [7:0] ch, input logic eon);
    name_word_t w;
    w.name_byte   = ch;
    w.end_of_name = eon;
    pending_words.push_back(w);
  endtask

  // a label character: never a dot, sometimes nul, often a letter
  function automatic logic [7:0] pick_char();
    int r;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 8) return NUL_CHAR;
    if (r < 50) return 8'($urandom_range(8'h7a, 8'h61));
    do c = 8'($urandom_range(255)); while (c == DOT_CHAR);
    return c;
  endfunction

  task automatic push_label(input int len);
    for (int i = 0; i < len; i++) push_word(pick_char(), 1'b0);
  endtask

  // mostly short labels, a few empty, a few within two of the cap
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 85) return $urandom_range(8, 1);
    if (r < 96) return $urandom_range(20, 9);
    return $urandom_range(LABEL_MAX + 2, LABEL_MAX - 2);
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int target;
    int n_labels;
    in_ch.valid       = 1'b0;
    in_ch.name_byte   = 8'h00;
    in_ch.end_of_name = 1'b0;
    out_ch.ready      = 1'b0;
    rst_n             = 1'b0;
    words_accepted    = 0;
    errors            = 0;
    label_len         = 0;
    label_lost        = 1'b0;

    // directed: empty name, end with a dot byte that must be ignored
    push_word(8'h00, 1'b1);
    push_word(DOT_CHAR, 1'b1);
    // lone dot gives one zero length byte with last
    push_word(DOT_CHAR, 1'b0);
    push_word(8'hff, 1'b1);
    // nul and extreme bytes stored as characters
    push_word(8'h61, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'hff, 1'b0);
    push_word(DOT_CHAR, 1'b0);
    push_word(8'h7f, 1'b0);
    push_word(8'h80, 1'b0);
    push_word(8'h2d, 1'b1);
    // double dot: empty label inside the name
    push_word(8'h78, 1'b0);
    push_word(DOT_CHAR, 1'b0);
    push_word(DOT_CHAR, 1'b0);
    push_word(8'h79, 1'b1);
    // trailing dot: empty label closed by the end mark
    push_word(8'h71, 1'b0);
    push_word(8'h72, 1'b0);
    push_word(DOT_CHAR, 1'b0);
    push_word(8'h55, 1'b1);

    target = pending_words.size() + 270;

    // labels one past the cap and exactly at it
    push_label(LABEL_MAX + 1);
    push_word(DOT_CHAR, 1'b0);
    push_label(LABEL_MAX);
    push_word(8'($urandom_range(255)), 1'b1);

    // random well-formed names, with stray dots mixed in
    while (pending_words.size() < target) begin
      n_labels = $urandom_range(4, 1);
      for (int l = 0; l < n_labels; l++) begin
        push_label(pick_len());
        if (l < n_labels - 1) push_word(DOT_CHAR, 1'b0);
      end
      if ($urandom_range(99) < 12) push_word(DOT_CHAR, 1'b0);
      push_word(8'($urandom_range(255)), 1'b1);
    end
    words_total = pending_words.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (words_accepted < words_total) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    // stray bytes after the last run would show up here
    repeat (150) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/dnle_pkg.sv
rtl/core/dnle_in_if.sv
rtl/core/dnle_out_if.sv
rtl/core/dnle_ram.sv
rtl/core/dnle_cmd_fifo.sv
rtl/core/dnle_front.sv
rtl/core/dnle_back.sv
rtl/core/dns_name_label_encoder_unit.sv
tb/sv/dns_name_label_encoder_unit_test.sv
